// ===== rtl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned LenOffset  = 56;

  typedef logic [31:0] word_t;
  typedef logic [7:0]  byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic init;
    logic step;
    logic add;
  } core_ctl_t;

  localparam word_t InitChain [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t ror(word_t v, int unsigned s);
    ror = (v >> s) | (v << (32 - s));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha256_if.sv =====
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message bytes and digests.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last;
  modport source (output valid, data_byte, byte_present, last, input ready);
  modport sink   (input valid, data_byte, byte_present, last, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_bits_255_192;
  logic [63:0] digest_bits_191_128;
  logic [63:0] digest_bits_127_64;
  logic [63:0] digest_bits_63_0;
  modport source (output valid, digest_bits_255_192, digest_bits_191_128,
                  digest_bits_127_64, digest_bits_63_0, input ready);
  modport sink   (input valid, digest_bits_255_192, digest_bits_191_128,
                  digest_bits_127_64, digest_bits_63_0, output ready);
endinterface
`default_nettype wire

// ===== rtl/sha256_core.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round core
// One shared round unit and chaining state over an outside 16-word schedule.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sha256_pkg::core_ctl_t ctl_i,
  input  wire logic [5:0]            round_i,
  input  wire sha256_pkg::word_t     sched_w_i,
  input  wire sha256_pkg::word_t     sched_n1_i,
  input  wire sha256_pkg::word_t     sched_n9_i,
  input  wire sha256_pkg::word_t     sched_n14_i,
  output sha256_pkg::word_t          sched_new_o,
  output logic [255:0]               chain_o
);
  sha256_pkg::word_t chain_q [8];
  sha256_pkg::word_t r_q [8];
  sha256_pkg::word_t s0, s1, sched_new, w, big0, big1, ch, maj, t1, t2;

  always_comb begin
    s0 = sha256_pkg::ror(sched_n1_i, 7) ^ sha256_pkg::ror(sched_n1_i, 18)
         ^ (sched_n1_i >> 3);
    s1 = sha256_pkg::ror(sched_n14_i, 17) ^ sha256_pkg::ror(sched_n14_i, 19)
         ^ (sched_n14_i >> 10);
    sched_new = s1 + sched_n9_i + s0 + sched_w_i;
    w    = (round_i >= 6'd16) ? sched_new : sched_w_i;
    big1 = sha256_pkg::ror(r_q[4], 6) ^ sha256_pkg::ror(r_q[4], 11)
           ^ sha256_pkg::ror(r_q[4], 25);
    ch   = (r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]);
    big0 = sha256_pkg::ror(r_q[0], 2) ^ sha256_pkg::ror(r_q[0], 13)
           ^ sha256_pkg::ror(r_q[0], 22);
    maj  = (r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]);
    t1   = r_q[7] + big1 + ch + sha256_pkg::RoundConst[round_i] + w;
    t2   = big0 + maj;
    for (int i = 0; i < 8; i++) chain_o[255-32*i -: 32] = chain_q[i];
  end

  assign sched_new_o = sched_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= sha256_pkg::InitChain[i];
    end else if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= sha256_pkg::InitChain[i];
    end else if (ctl_i.add) begin
      for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + r_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.step) begin
      r_q[7] <= r_q[6]; r_q[6] <= r_q[5]; r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2]; r_q[2] <= r_q[1]; r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end else if (!(ctl_i.add || ctl_i.init)) begin
      for (int i = 0; i < 8; i++) r_q[i] <= chain_q[i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Buffers message bytes into 64-byte blocks and compresses each block.
// ----------------------------------------------------------------------------
// Usage: in_i carries one message byte a beat (byte_present, last). A byte
// that does not fill a block is taken at once. A byte that fills a block
// holds ready low through the load, the rounds and the add. A beat with last
// pads the message (one or two extra compressions, each a pad pass over the
// 16 schedule words, a load, the rounds and an add) and then presents the
// digest on out_o. The digest stays until out_o is taken; no beat is
// accepted meanwhile. After that the chaining state is back at the initial
// values.
// Reset puts the chaining state at the initial values and empties the buffer.
// The buffer is a 16-word schedule memory; each round reads the words at
// offsets 0, 1, 9 and 14; rounds from 16 on write the new word back in place.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_byte_stream_hasher (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  sha256_in_if.sink          in_i,
  sha256_out_if.source       out_o
);
  sha256_pkg::state_e state_q, state_d;
  sha256_pkg::word_t  buf_q [16];
  logic [5:0]  fill_q, fill_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] total_q, total_d;
  logic [5:0]  round_q, round_d;
  logic        fin_q, fin_d;         // finishing message
  logic        extra_q, extra_d;     // padding needs a second block
  logic        pad_blk_q, pad_blk_d; // current block holds padding
  logic [3:0]  pad_q, pad_d;
  sha256_pkg::core_ctl_t ctl;
  sha256_pkg::word_t sched_new;
  logic [255:0] chain;
  logic [3:0] wi;
  logic [5:0] pad_idx;
  logic       buf_byte_we, buf_word_we, buf_pad_we;
  sha256_pkg::word_t pad_word;

  assign wi = round_q[3:0];

  sha256_core u_core (
    .clk_i, .rst_ni, .ctl_i(ctl), .round_i(round_q),
    .sched_w_i(buf_q[wi]), .sched_n1_i(buf_q[wi + 4'd1]),
    .sched_n9_i(buf_q[wi + 4'd9]), .sched_n14_i(buf_q[wi + 4'd14]),
    .sched_new_o(sched_new), .chain_o(chain)
  );

  assign out_o.digest_bits_255_192 = chain[255:192];
  assign out_o.digest_bits_191_128 = chain[191:128];
  assign out_o.digest_bits_127_64  = chain[127:64];
  assign out_o.digest_bits_63_0    = chain[63:0];

  // keep bytes below fill, 0x80 at fill, zero above, length in the last block
  always_comb begin
    pad_word = '0;
    pad_idx  = '0;
    for (int b = 0; b < 4; b++) begin
      pad_idx = {pad_q, 2'(b)};
      if (!extra_q) begin
        if (pad_idx == fill_q) pad_word[31-8*b -: 8] = 8'h80;
        else if (pad_idx < fill_q) pad_word[31-8*b -: 8] = buf_q[pad_q][31-8*b -: 8];
      end
    end
    if (extra_q || fill_q < 6'(sha256_pkg::LenOffset)) begin
      if (pad_q == 4'd14) pad_word = total_q[63:32];
      if (pad_q == 4'd15) pad_word = total_q[31:0];
    end
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; bits_d = bits_q; total_d = total_q;
    round_d = round_q; fin_d = fin_q; extra_d = extra_q; pad_d = pad_q;
    pad_blk_d = pad_blk_q;
    ctl = '0; in_i.ready = 1'b0; out_o.valid = 1'b0;
    buf_byte_we = 1'b0; buf_word_we = 1'b0; buf_pad_we = 1'b0;
    unique case (state_q)
      sha256_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.byte_present) begin
            buf_byte_we = 1'b1;
            fill_d = fill_q + 6'd1;
          end
          fin_d = in_i.last; extra_d = 1'b0; pad_blk_d = 1'b0;
          if (in_i.byte_present && fill_q == 6'd63) begin
            state_d = sha256_pkg::ST_LOAD; round_d = '0;
          end else if (in_i.last) begin
            total_d = bits_q + {55'd0, fill_d, 3'd0};
            state_d = sha256_pkg::ST_PAD; pad_d = '0;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        buf_pad_we = 1'b1;
        pad_blk_d = 1'b1;
        pad_d = pad_q + 4'd1;
        if (pad_q == 4'd15) begin
          state_d = sha256_pkg::ST_LOAD; round_d = '0;
        end
      end
      sha256_pkg::ST_LOAD: begin
        state_d = sha256_pkg::ST_ROUND;
      end
      sha256_pkg::ST_ROUND: begin
        ctl.step = 1'b1;
        if (round_q >= 6'd16) buf_word_we = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == 6'(sha256_pkg::Rounds - 1)) state_d = sha256_pkg::ST_ADD;
      end
      sha256_pkg::ST_ADD: begin
        ctl.add = 1'b1;
        if (!pad_blk_q) begin
          bits_d = bits_q + 64'd512; fill_d = '0;
          if (fin_q) begin
            total_d = bits_q + 64'd512; pad_d = '0; extra_d = 1'b0;
            state_d = sha256_pkg::ST_PAD;
          end else begin
            state_d = sha256_pkg::ST_IDLE;
          end
        end else if (!extra_q && fill_q >= 6'(sha256_pkg::LenOffset)) begin
          extra_d = 1'b1; pad_d = '0; state_d = sha256_pkg::ST_PAD;
        end else begin
          state_d = sha256_pkg::ST_OUT;
        end
      end
      sha256_pkg::ST_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          ctl.init = 1'b1; fill_d = '0; bits_d = '0; fin_d = 1'b0;
          extra_d = 1'b0; pad_blk_d = 1'b0;
          state_d = sha256_pkg::ST_IDLE;
        end
      end
      default: state_d = sha256_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::ST_IDLE;
      fill_q <= '0; bits_q <= '0; total_q <= '0; round_q <= '0;
      fin_q <= 1'b0; extra_q <= 1'b0; pad_blk_q <= 1'b0; pad_q <= '0;
    end else begin
      state_q <= state_d; fill_q <= fill_d; bits_q <= bits_d; total_q <= total_d;
      round_q <= round_d; fin_q <= fin_d;
      extra_q <= extra_d; pad_blk_q <= pad_blk_d; pad_q <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_byte_we) buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= in_i.data_byte;
    if (buf_word_we) buf_q[wi] <= sched_new;
    if (buf_pad_we)  buf_q[pad_q] <= pad_word;
  end
endmodule
`default_nettype wire
